// ----- src/wgm_pkg.sv -----
// Shared types, constants and helpers for the glob matcher.
// Used by every module of the block; depends on nothing.
package wgm_pkg;

    // Buffer and pattern sizing
    localparam int NAME_MAX    = 64;
    localparam int PATTERN_MAX = 16;
    localparam int NAME_AW     = $clog2(NAME_MAX);
    localparam int NAME_LW     = $clog2(NAME_MAX + 1);
    localparam int NUM_BANKS   = 2;
    localparam int BUF_AW      = NAME_AW + $clog2(NUM_BANKS);
    localparam int BUF_DEPTH   = 2 ** BUF_AW;
    localparam int JOB_CW      = $clog2(NUM_BANKS + 1);
    localparam int PAT_LW      = 5;
    localparam int PAT_IW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAT_BITS    = 128;
    localparam int CFG_DW      = 64;
    localparam int CFG_IW      = 2;

    // Pattern codes
    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] ANY_CODE  = 8'h3F;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_PAT_LEN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PAT_LO  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_PAT_HI  = 2'd2;

    // One finished name handed from the front to the back
    typedef struct packed {
        logic [NAME_LW-1:0] len;
        logic               ovf;
        logic               bank;
    } t_job;

    // Active pattern, length already clamped
    typedef struct packed {
        logic [PAT_LW-1:0]   len;
        logic [PAT_BITS-1:0] chars;
    } t_pat;

    function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] chars,
                                            input logic [PAT_IW-1:0]   idx);
        return chars[idx*8 +: 8];
    endfunction

endpackage

// ----- src/wgm_front.sv -----
// Front end: takes name bytes, fills one of two name banks, and issues a job
// per name. Holds the name buffer memory. Depends on wgm_pkg.
module wgm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_name_char,
    input  logic                       i_last_char,
    input  logic                       i_empty_name,
    output logic                       o_push,
    output wgm_pkg::t_job              o_job,
    input  logic                       i_release,
    input  logic [wgm_pkg::BUF_AW-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);

    logic [7:0]                  r_buf [wgm_pkg::BUF_DEPTH];
    logic [7:0]                  r_rd_data;
    logic [wgm_pkg::NAME_LW-1:0] r_wlen, n_wlen;
    logic                        r_ovf, n_ovf;
    logic                        r_wbank, n_wbank;
    logic [wgm_pkg::JOB_CW-1:0]  r_jobs, n_jobs;
    logic                        accept;
    logic                        wr_en;

    function automatic logic [wgm_pkg::JOB_CW-1:0] JOB_ONE(input logic b);
        return {{(wgm_pkg::JOB_CW-1){1'b0}}, b};
    endfunction

    // A bank is free while fewer than two names are outstanding
    assign o_ready = (r_jobs != wgm_pkg::JOB_CW'(wgm_pkg::NUM_BANKS));
    assign accept  = i_valid && o_ready;
    assign wr_en   = accept && !i_empty_name
                     && (r_wlen < wgm_pkg::NAME_LW'(wgm_pkg::NAME_MAX));
    assign o_push  = accept && (i_empty_name || i_last_char);

    // Job contents for the name that ends with this request
    always_comb begin
        o_job.bank = r_wbank;
        if (i_empty_name) begin
            o_job.len = '0;
            o_job.ovf = 1'b0;
        end else begin
            o_job.len = wr_en ? r_wlen + 1'b1 : r_wlen;
            o_job.ovf = r_ovf || !wr_en;
        end
    end

    // Fill state and bank ownership
    always_comb begin
        n_wlen  = r_wlen;
        n_ovf   = r_ovf;
        n_wbank = r_wbank;
        if (o_push) begin
            n_wlen  = '0;
            n_ovf   = 1'b0;
            n_wbank = !r_wbank;
        end else if (accept) begin
            n_wlen = o_job.len;
            n_ovf  = o_job.ovf;
        end
        n_jobs = r_jobs + JOB_ONE(o_push) - JOB_ONE(i_release);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= 1'b0;
            r_jobs  <= '0;
        end else begin
            r_wlen  <= n_wlen;
            r_ovf   <= n_ovf;
            r_wbank <= n_wbank;
            r_jobs  <= n_jobs;
        end
    end

    // Name buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[{r_wbank, r_wlen[wgm_pkg::NAME_AW-1:0]}] <= i_name_char;
        end
        r_rd_data <= r_buf[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/wgm_jobq.sv -----
// Two-entry job queue between the front and the back.
// Depends on wgm_pkg for the job type.
module wgm_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wgm_pkg::t_job i_job,
    input  logic          i_pop,
    output wgm_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    wgm_pkg::t_job r_slot [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;

    assign o_job   = r_slot[r_rptr];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

// ----- src/wgm_back.sv -----
// Back end: walks one buffered name against the pattern with single-star
// backtracking, one step per cycle, and holds the result register.
// Depends on wgm_pkg.
module wgm_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_empty,
    input  wgm_pkg::t_job              i_job,
    output logic                       o_pop,
    input  wgm_pkg::t_pat              i_pat,
    output logic [wgm_pkg::BUF_AW-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_release,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_matched,
    output logic                       o_too_long
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_TAIL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_bank, n_bank;
    logic [wgm_pkg::NAME_LW-1:0] r_nlen, n_nlen;
    logic [wgm_pkg::NAME_LW-1:0] r_np, n_np;
    logic [wgm_pkg::NAME_LW-1:0] r_snp, n_snp;
    logic [wgm_pkg::PAT_LW-1:0]  r_pp, n_pp;
    logic [wgm_pkg::PAT_LW-1:0]  r_spp, n_spp;
    logic                        r_star, n_star;
    logic                        r_res, n_res;
    logic                        r_tl, n_tl;
    logic                        r_out_valid;
    logic                        r_matched;
    logic                        r_too_long;
    logic                        pvalid;
    logic [7:0]                  pch;
    logic                        load_out;

    assign pvalid = (r_pp < i_pat.len);
    assign pch    = wgm_pkg::pat_byte(i_pat.chars, r_pp[wgm_pkg::PAT_IW-1:0]);

    // Walk sequencer
    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_nlen   = r_nlen;
        n_np     = r_np;
        n_snp    = r_snp;
        n_pp     = r_pp;
        n_spp    = r_spp;
        n_star   = r_star;
        n_res    = r_res;
        n_tl     = r_tl;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_pop  = 1'b1;
                    n_bank = i_job.bank;
                    n_nlen = i_job.len;
                    n_np   = '0;
                    n_pp   = '0;
                    n_star = 1'b0;
                    n_res  = 1'b0;
                    n_tl   = i_job.ovf;
                    n_state = i_job.ovf ? S_DONE : S_STEP;
                end
            end
            S_STEP: begin
                if (r_np >= r_nlen) begin
                    n_state = S_TAIL;
                end else if (pvalid && (pch == wgm_pkg::ANY_CODE || pch == i_rd_data)) begin
                    n_pp = r_pp + 1'b1;
                    n_np = r_np + 1'b1;
                end else if (pvalid && pch == wgm_pkg::STAR_CODE) begin
                    n_star = 1'b1;
                    n_spp  = r_pp;
                    n_snp  = r_np;
                    n_pp   = r_pp + 1'b1;
                end else if (r_star) begin
                    n_pp  = r_spp + 1'b1;
                    n_snp = r_snp + 1'b1;
                    n_np  = r_snp + 1'b1;
                end else begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_TAIL: begin
                // Trailing stars match the empty rest of the name
                if (pvalid && pch == wgm_pkg::STAR_CODE) begin
                    n_pp = r_pp + 1'b1;
                end else begin
                    n_res   = (r_pp == i_pat.len);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read the byte the next step needs
    assign o_rd_addr = {n_bank, n_np[wgm_pkg::NAME_AW-1:0]};
    assign o_release = load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers and result register
    always_ff @(posedge i_clk) begin
        r_bank <= n_bank;
        r_nlen <= n_nlen;
        r_np   <= n_np;
        r_snp  <= n_snp;
        r_pp   <= n_pp;
        r_spp  <= n_spp;
        r_star <= n_star;
        r_res  <= n_res;
        r_tl   <= n_tl;
        if (load_out) begin
            r_matched  <= r_res && !r_tl;
            r_too_long <= r_tl;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_too_long = r_too_long;

endmodule

// ----- src/wildcard_glob_match.sv -----
// Glob matcher top level: '*' and '?' wildcards against streamed names.
// Name bytes are taken one per cycle; two name banks let the next name load
// while the back end walks the previous one; input stalls only with two names
// outstanding. With the back end idle, a result loads after the walk steps (at
// most about len*(plen+1)+plen) and the tail state; a too-long name skips both.
// Reset is synchronous, active low; it clears control and config, not the buffer.
module wildcard_glob_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wgm_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [wgm_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_name_char,
    input  logic                        i_last_char,
    input  logic                        i_empty_name,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_matched,
    output logic                        o_too_long
);

    logic [wgm_pkg::PAT_LW-1:0] r_pat_len;
    logic [wgm_pkg::CFG_DW-1:0] r_pat_lo;
    logic [wgm_pkg::CFG_DW-1:0] r_pat_hi;
    wgm_pkg::t_pat              pat;
    wgm_pkg::t_job              push_job;
    wgm_pkg::t_job              head_job;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_empty;
    logic                       q_full;
    logic                       rel;
    logic [wgm_pkg::BUF_AW-1:0] rd_addr;
    logic [7:0]                 rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wgm_pkg::CFG_PAT_LEN: r_pat_len <= i_cfg_data[wgm_pkg::PAT_LW-1:0];
                wgm_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                wgm_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp pattern length to the pattern capacity
    always_comb begin
        pat.chars = {r_pat_hi, r_pat_lo};
        if (r_pat_len > wgm_pkg::PAT_LW'(wgm_pkg::PATTERN_MAX)) begin
            pat.len = wgm_pkg::PAT_LW'(wgm_pkg::PATTERN_MAX);
        end else begin
            pat.len = r_pat_len;
        end
    end

    wgm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_name_char  (i_name_char),
        .i_last_char  (i_last_char),
        .i_empty_name (i_empty_name),
        .o_push       (q_push),
        .o_job        (push_job),
        .i_release    (rel),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (rd_data)
    );

    wgm_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .i_pat       (pat),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (rel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_matched   (o_matched),
        .o_too_long  (o_too_long)
    );

    // Bank accounting keeps the job queue from overflowing
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("job pushed into a full queue");

    // A too-long name never reports a match
    a_tl_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_matched && o_too_long))
        else $error("matched set together with too_long");

    // A result held by back-pressure stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_matched, o_too_long})))
        else $error("result changed while waiting");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

endmodule

// ----- tb/wildcard_glob_match_tb.sv -----
// Self-checking testbench for wildcard_glob_match: streams names against glob patterns
// and checks each match verdict against an in-bench model of the backtracking walk.
// Depends on wgm_pkg and the wildcard_glob_match RTL only.
module wildcard_glob_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_char_q [$];

    typedef struct packed {
        logic matched;
        logic too_long;
    } t_verdict;

    // Scoreboard: mirrors config and name buffer, predicts one verdict per name
    class glob_scoreboard;
        logic [wgm_pkg::PAT_LW-1:0]  pat_len_reg = '0;
        logic [wgm_pkg::CFG_DW-1:0]  pat_lo      = '0;
        logic [wgm_pkg::CFG_DW-1:0]  pat_hi      = '0;
        logic [7:0]                  name_buf [wgm_pkg::NAME_MAX];
        logic [6:0]                  name_len    = '0;
        logic                        name_ovf    = 1'b0;
        t_verdict                    verdicts_due [$];
        int                          fail_count  = 0;

        function void record_fail(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%s", msg);
        endfunction

        function void write_reg(logic [wgm_pkg::CFG_IW-1:0] idx,
                                logic [wgm_pkg::CFG_DW-1:0] data);
            case (idx)
                wgm_pkg::CFG_PAT_LEN: pat_len_reg = data[wgm_pkg::PAT_LW-1:0];
                wgm_pkg::CFG_PAT_LO:  pat_lo = data;
                wgm_pkg::CFG_PAT_HI:  pat_hi = data;
                default: ;
            endcase
        endfunction

        // Greedy walk, backing up to the most recent star on a miss
        function bit glob_walk();
            int                           plen;
            int                           p;
            int                           n;
            int                           star_p;
            int                           star_n;
            bit                           have_star;
            logic [7:0]                   pc;
            logic [wgm_pkg::PAT_BITS-1:0] chars;
            plen = (pat_len_reg > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX
                                                        : int'(pat_len_reg);
            chars = {pat_hi, pat_lo};
            p = 0;
            n = 0;
            star_p = 0;
            star_n = 0;
            have_star = 1'b0;
            while (n < name_len) begin
                pc = (p < plen) ? chars[p*8 +: 8] : 8'h00;
                if (p < plen && (pc == wgm_pkg::ANY_CODE || pc == name_buf[n])) begin
                    p++;
                    n++;
                end else if (p < plen && pc == wgm_pkg::STAR_CODE) begin
                    have_star = 1'b1;
                    star_p = p;
                    star_n = n;
                    p++;
                end else if (have_star) begin
                    p = star_p + 1;
                    star_n++;
                    n = star_n;
                end else begin
                    return 1'b0;
                end
            end
            // trailing stars match the empty rest
            while (p < plen && chars[p*8 +: 8] == wgm_pkg::STAR_CODE)
                p++;
            return p == plen;
        endfunction

        function void note_request(logic [7:0] ch, logic last, logic empty);
            t_verdict v;
            if (empty) begin
                name_len = '0;
                name_ovf = 1'b0;
            end else begin
                if (name_len < wgm_pkg::NAME_MAX) begin
                    name_buf[name_len] = ch;
                    name_len++;
                end else begin
                    name_ovf = 1'b1;
                end
                if (!last)
                    return;
            end
            v.too_long = name_ovf;
            v.matched  = name_ovf ? 1'b0 : glob_walk();
            verdicts_due.insert(verdicts_due.size(), v);
            name_len = '0;
            name_ovf = 1'b0;
        endfunction

        function void check_result(logic matched, logic too_long);
            t_verdict v;
            if (verdicts_due.size() == 0) begin
                record_fail($sformatf("unexpected result matched=%b too_long=%b",
                                      matched, too_long));
                return;
            end
            v = verdicts_due.pop_front();
            if (v.matched !== matched || v.too_long !== too_long)
                record_fail($sformatf({"result differs: expected matched=%b too_long=%b,",
                                       " got matched=%b too_long=%b"},
                                      v.matched, v.too_long, matched, too_long));
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [wgm_pkg::CFG_IW-1:0]  i_cfg_idx;
    logic [wgm_pkg::CFG_DW-1:0]  i_cfg_data;
    logic                        i_valid;
    logic                        o_ready;
    logic [7:0]                  i_name_char;
    logic                        i_last_char;
    logic                        i_empty_name;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic                        o_matched;
    logic                        o_too_long;

    glob_scoreboard sb = new;
    int idle_pct  = 30;
    int stall_pct = 30;
    int items_sent = 0;

    wildcard_glob_match dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_name_char  (i_name_char),
        .i_last_char  (i_last_char),
        .i_empty_name (i_empty_name),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_matched    (o_matched),
        .o_too_long   (o_too_long)
    );

    always #10 i_clk = ~i_clk;

    // Result side: random back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_matched, o_too_long);
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("wildcard_glob_match: mismatch");
        $finish;
    end

    // One request; returns at the accepting edge
    task automatic send_char(input logic [7:0] ch, input logic last, input logic empty);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_name_char  <= ch;
        i_last_char  <= last;
        i_empty_name <= empty;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_request(ch, last, empty);
        items_sent++;
    endtask

    // Whole name; an empty queue goes out as the empty-name flag
    task automatic send_name(input t_char_q q);
        if (q.size() == 0) begin
            send_char(8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            foreach (q[i])
                send_char(q[i], i == q.size() - 1, 1'b0);
        end
    endtask

    task automatic send_text(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++)
            q.insert(q.size(), s[i]);
        send_name(q);
    endtask

    task automatic write_reg(input logic [wgm_pkg::CFG_IW-1:0] idx,
                             input logic [wgm_pkg::CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Drain outstanding verdicts, let the walk settle, then load a new pattern
    task automatic set_pattern(input logic [wgm_pkg::PAT_LW-1:0] len,
                               input logic [wgm_pkg::PAT_BITS-1:0] chars);
        logic [wgm_pkg::CFG_DW-1:0] len_data;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        len_data = {$urandom(), $urandom()};
        len_data[wgm_pkg::PAT_LW-1:0] = len;
        write_reg(wgm_pkg::CFG_PAT_LEN, len_data);
        write_reg(wgm_pkg::CFG_PAT_LO, chars[63:0]);
        write_reg(wgm_pkg::CFG_PAT_HI, chars[127:64]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [wgm_pkg::PAT_BITS-1:0] pack_text(input string s);
        logic [wgm_pkg::PAT_BITS-1:0] chars;
        chars = '0;
        for (int i = 0; i < s.len() && i < wgm_pkg::PATTERN_MAX; i++)
            chars[i*8 +: 8] = s[i];
        return chars;
    endfunction

    // Mostly a/b/c, now and then a wildcard byte used literally
    function automatic logic [7:0] random_letter();
        case ($urandom_range(9))
            0:       return wgm_pkg::STAR_CODE;
            1:       return wgm_pkg::ANY_CODE;
            default: return 8'h61 + 8'($urandom_range(2));
        endcase
    endfunction

    function automatic logic [wgm_pkg::PAT_BITS-1:0] random_pattern(input int len);
        logic [wgm_pkg::PAT_BITS-1:0] chars;
        for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
            if (i >= len || $urandom_range(9) == 0)
                chars[i*8 +: 8] = 8'($urandom_range(255));
            else if ($urandom_range(99) < 20)
                chars[i*8 +: 8] = wgm_pkg::STAR_CODE;
            else if ($urandom_range(99) < 20)
                chars[i*8 +: 8] = wgm_pkg::ANY_CODE;
            else
                chars[i*8 +: 8] = 8'h61 + 8'($urandom_range(2));
        end
        return chars;
    endfunction

    // Expand the pattern into a likely match, then maybe damage it
    function automatic t_char_q name_from_pattern(input int len,
                                                  input logic [wgm_pkg::PAT_BITS-1:0] chars);
        t_char_q    q;
        logic [7:0] pc;
        int         plen;
        plen = (len > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX : len;
        for (int i = 0; i < plen; i++) begin
            pc = chars[i*8 +: 8];
            if (pc == wgm_pkg::STAR_CODE)
                repeat ($urandom_range(3)) q.insert(q.size(), random_letter());
            else if (pc == wgm_pkg::ANY_CODE)
                q.insert(q.size(), random_letter());
            else
                q.insert(q.size(), pc);
        end
        case ($urandom_range(9))
            0: if (q.size() > 0) q[$urandom_range(q.size() - 1)] = random_letter();
            1: if (q.size() > 0) void'(q.pop_back());
            2: q.insert(q.size(), random_letter());
            default: ;
        endcase
        return q;
    endfunction

    initial begin
        t_char_q                      q;
        logic [wgm_pkg::PAT_BITS-1:0] chars;
        int                           plen;
        int                           phase_end;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = wgm_pkg::CFG_PAT_LEN;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_name_char  = '0;
        i_last_char  = 1'b0;
        i_empty_name = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pattern is empty: only the empty name matches
        send_name(q);
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);

        set_pattern(5'd5, pack_text("a*b?c"));
        send_text("abxc");
        send_text("aqqbzc");
        send_text("abc");
        send_text("ab*?c");
        // partial name thrown away by the empty flag without last
        send_char(8'h61, 1'b0, 1'b0);
        send_char(8'h62, 1'b0, 1'b0);
        send_char(8'hA5, 1'b0, 1'b1);

        // Oversized length clamps to the full 16; last byte sits in the high word
        set_pattern(5'd31, pack_text("***************z"));
        send_text("z");
        send_text("abz");
        send_text("zy");
        send_char(8'h5A, 1'b1, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       plen = 0;
                1:       plen = 16;
                2:       plen = $urandom_range(17, 31);
                default: plen = $urandom_range(1, 10);
            endcase
            chars = random_pattern(plen);
            set_pattern(plen[wgm_pkg::PAT_LW-1:0], chars);
            idle_pct  = (ph == 3) ? 0 : 30;
            stall_pct = (ph == 3) ? 0 : 30;
            phase_end = items_sent + 85;

            // one full-buffer or overflowing name in a few phases
            if (ph == 1 || ph == 4 || ph == 6) begin
                q = {};
                repeat ((ph == 1) ? 64 : (ph == 4) ? 65 : $urandom_range(66, 72))
                    q.insert(q.size(), random_letter());
                send_name(q);
            end

            while (items_sent < phase_end) begin
                q = {};
                case ($urandom_range(99)) inside
                    [0:59]:  q = name_from_pattern(plen, chars);
                    [60:79]: repeat ($urandom_range(1, 8))
                                 q.insert(q.size(), random_letter());
                    [80:89]: repeat ($urandom_range(1, 6))
                                 q.insert(q.size(), 8'($urandom_range(255)));
                    [90:98]: begin
                        repeat ($urandom_range(0, 3))
                            send_char(random_letter(), 1'b0, 1'b0);
                        send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                        continue;
                    end
                    default: repeat ($urandom_range(63, 70))
                                 q.insert(q.size(), random_letter());
                endcase
                send_name(q);
            end
        end

        // Drain and allow time for any stray result
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        while (sb.verdicts_due.size() != 0) begin
            void'(sb.verdicts_due.pop_front());
            sb.record_fail("expected result never arrived");
        end

        if (sb.fail_count == 0) begin
            $display("wildcard_glob_match: match");
        end else begin
            $display("wildcard_glob_match: mismatch");
        end
        $finish;
    end

endmodule
